### rtl/core/sbs_pkg.sv
package sbs_pkg;

  // word and field widths
  localparam int unsigned DATA_W        = 32;
  localparam int unsigned USED_W        = 6;
  localparam int unsigned WORDS_DEFAULT = 32;

  // largest count that the used-word field can carry
  localparam logic [USED_W-1:0] USED_MAX = {USED_W{1'b1}};

  // sign pair codes, minuend sign in bit 1, subtrahend sign in bit 0
  localparam logic [1:0] SIGNS_POS_POS = 2'b00;
  localparam logic [1:0] SIGNS_POS_NEG = 2'b01;
  localparam logic [1:0] SIGNS_NEG_POS = 2'b10;
  localparam logic [1:0] SIGNS_NEG_NEG = 2'b11;

endpackage

### rtl/core/sbs_ifs.sv
// operand word channel
interface sbs_in_if
  import sbs_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] a_word;
  logic [DATA_W-1:0] b_word;
  logic              a_negative;
  logic              b_negative;
  logic              final_word;

  modport source (
    output valid, a_word, b_word, a_negative, b_negative, final_word,
    input  ready
  );
  modport sink (
    input  valid, a_word, b_word, a_negative, b_negative, final_word,
    output ready
  );
endinterface

// result word channel
interface sbs_out_if
  import sbs_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] result_word;
  logic              result_negative;
  logic [USED_W-1:0] used_words;
  logic              overflow;
  logic              last_result;

  modport source (
    output valid, result_word, result_negative, used_words, overflow, last_result,
    input  ready
  );
  modport sink (
    input  valid, result_word, result_negative, used_words, overflow, last_result,
    output ready
  );
endinterface

### rtl/core/signed_bignum_subtractor_unit.sv
// Sign-magnitude multiword subtractor: result = a - b.
// in_chan carries one word pair per transaction, most significant first; the
// transaction with final_word set brings the least significant pair and both
// signs and starts the operation. Up to WORDS pairs are kept; with more, only
// the last WORDS pairs count.
// out_chan returns one transaction per loaded word, most significant first,
// with the result sign and used-word count repeated on each and last_result
// on the final one. A magnitude addition that carries out of the top word
// gives a single transaction with overflow and last_result set, all other
// fields zero. All operand words sit in one 64-bit wide single-port-read
// memory, so the magnitude compare and the add or subtract pass each take
// one word a cycle; each result word is read from memory, then presented.
// The first result word is offered once the final word is taken and the
// compare pass, the add or subtract pass and the read of that word have run.
// in_chan.ready is high only while loading; no new word is taken until the
// last result transaction has gone. A stall on out_chan simply holds the
// current result. Synchronous reset returns the block to loading with an
// empty word count; memory contents are not cleared.
module signed_bignum_subtractor_unit
  import sbs_pkg::*;
#(
  parameter int unsigned WORDS = WORDS_DEFAULT
) (
  input  logic     clk,
  input  logic     rst_n,
  sbs_in_if.sink   in_chan,
  sbs_out_if.source out_chan
);

  localparam int unsigned AW   = $clog2(WORDS);
  localparam int unsigned CNTW = $clog2(WORDS + 1);
  localparam int unsigned SW   = $clog2(2 * WORDS);
  localparam int unsigned MW   = 2 * DATA_W;

  typedef enum logic [2:0] {
    S_LOAD,
    S_CMP,
    S_ARITH,
    S_OVF,
    S_EMIT_RD,
    S_EMIT_OUT
  } state_t;

  function automatic logic [AW-1:0] addr_inc(input logic [AW-1:0] a);
    logic [AW-1:0] r;
    r = (a == AW'(WORDS - 1)) ? '0 : a + AW'(1);
    return r;
  endfunction

  function automatic logic [AW-1:0] addr_dec(input logic [AW-1:0] a);
    logic [AW-1:0] r;
    r = (a == '0) ? AW'(WORDS - 1) : a - AW'(1);
    return r;
  endfunction

  state_t            state_r, state_nxt;
  logic [AW-1:0]     ptr_r, ptr_nxt;
  logic [CNTW-1:0]   n_r, n_nxt;
  logic [1:0]        sign_r, sign_nxt;
  logic [AW-1:0]     start_r, start_nxt;
  logic [AW-1:0]     lsw_r, lsw_nxt;
  logic [AW-1:0]     addr_r, addr_nxt;
  logic [AW-1:0]     wb_addr_r, wb_addr_nxt;
  logic [CNTW-1:0]   iss_cnt_r, iss_cnt_nxt;
  logic [CNTW-1:0]   proc_cnt_r, proc_cnt_nxt;
  logic              pend_r, pend_nxt;
  logic              dec_r, dec_nxt;
  logic              lt_r, lt_nxt;
  logic              carry_r, carry_nxt;
  logic [CNTW-1:0]   used_r, used_nxt;

  // operand memory, minuend word in the upper half
  logic [MW-1:0]     mem [WORDS];
  logic [MW-1:0]     mem_q;
  logic              mem_wr_en;
  logic [AW-1:0]     mem_wr_addr;
  logic [MW-1:0]     mem_wr_data;
  logic              mem_rd_en;

  logic [DATA_W-1:0] op_a, op_b, big, small_op;
  logic              add_mode;
  logic [DATA_W:0]   sum;
  logic [CNTW-1:0]   n_last;
  logic [CNTW-1:0]   n_load;
  logic [AW-1:0]     ptr_inc;
  logic [SW-1:0]     start_sum;
  logic [6:0]        used_ext;
  logic [USED_W-1:0] used_sat;
  logic              neg;

  // word pair as read back, magnitudes ordered by the compare result
  assign op_a     = mem_q[MW-1:DATA_W];
  assign op_b     = mem_q[DATA_W-1:0];
  assign big      = lt_r ? op_b : op_a;
  assign small_op = lt_r ? op_a : op_b;
  assign add_mode = (sign_r == SIGNS_POS_NEG) || (sign_r == SIGNS_NEG_POS);
  assign sum      = add_mode ?
                    ({1'b0, big} + {1'b0, small_op} + (DATA_W+1)'(carry_r)) :
                    ({1'b0, big} - {1'b0, small_op} - (DATA_W+1)'(carry_r));
  assign n_last   = n_r - CNTW'(1);

  // load bookkeeping: count saturates, oldest kept word sits at start
  assign ptr_inc   = addr_inc(ptr_r);
  assign n_load    = (n_r == CNTW'(WORDS)) ? n_r : n_r + CNTW'(1);
  always_comb begin
    start_sum = SW'(ptr_inc) + SW'(WORDS) - SW'(n_load);
    if (start_sum >= SW'(WORDS)) begin
      start_sum = start_sum - SW'(WORDS);
    end
  end

  // result sign and saturated used-word count
  assign used_ext = 7'(used_r);
  assign used_sat = (used_ext > 7'(USED_MAX)) ? USED_MAX : used_ext[USED_W-1:0];
  always_comb begin
    unique case (sign_r)
      SIGNS_POS_POS: neg = lt_r;
      SIGNS_POS_NEG: neg = 1'b0;
      SIGNS_NEG_POS: neg = 1'b1;
      SIGNS_NEG_NEG: neg = !lt_r && (used_r != '0);
      default:       neg = 1'b0;
    endcase
  end

  // channel outputs
  assign in_chan.ready            = (state_r == S_LOAD);
  assign out_chan.valid           = (state_r == S_EMIT_OUT) || (state_r == S_OVF);
  assign out_chan.result_word     = (state_r == S_OVF) ? '0 : op_a;
  assign out_chan.result_negative = (state_r == S_OVF) ? 1'b0 : neg;
  assign out_chan.used_words      = (state_r == S_OVF) ? '0 : used_sat;
  assign out_chan.overflow        = (state_r == S_OVF);
  assign out_chan.last_result     = (state_r == S_OVF) || (proc_cnt_r == n_last);

  // sequencer
  always_comb begin
    state_nxt    = state_r;
    ptr_nxt      = ptr_r;
    n_nxt        = n_r;
    sign_nxt     = sign_r;
    start_nxt    = start_r;
    lsw_nxt      = lsw_r;
    addr_nxt     = addr_r;
    wb_addr_nxt  = wb_addr_r;
    iss_cnt_nxt  = iss_cnt_r;
    proc_cnt_nxt = proc_cnt_r;
    pend_nxt     = pend_r;
    dec_nxt      = dec_r;
    lt_nxt       = lt_r;
    carry_nxt    = carry_r;
    used_nxt     = used_r;
    mem_wr_en    = 1'b0;
    mem_wr_addr  = ptr_r;
    mem_wr_data  = {in_chan.a_word, in_chan.b_word};
    mem_rd_en    = 1'b0;

    unique case (state_r)
      S_LOAD: begin
        if (in_chan.valid) begin
          mem_wr_en = 1'b1;
          ptr_nxt   = ptr_inc;
          n_nxt     = n_load;
          if (in_chan.final_word) begin
            sign_nxt     = {in_chan.a_negative, in_chan.b_negative};
            lsw_nxt      = ptr_r;
            start_nxt    = AW'(start_sum);
            addr_nxt     = AW'(start_sum);
            ptr_nxt      = '0;
            iss_cnt_nxt  = '0;
            proc_cnt_nxt = '0;
            pend_nxt     = 1'b0;
            dec_nxt      = 1'b0;
            lt_nxt       = 1'b0;
            state_nxt    = S_CMP;
          end
        end
      end

      // magnitude compare, most significant word first
      S_CMP: begin
        pend_nxt = 1'b0;
        if (iss_cnt_r != n_r) begin
          mem_rd_en   = 1'b1;
          addr_nxt    = addr_inc(addr_r);
          iss_cnt_nxt = iss_cnt_r + CNTW'(1);
          pend_nxt    = 1'b1;
        end
        if (pend_r) begin
          if (!dec_r && (op_a != op_b)) begin
            dec_nxt = 1'b1;
            lt_nxt  = (op_a < op_b);
          end
          proc_cnt_nxt = proc_cnt_r + CNTW'(1);
          if (proc_cnt_r == n_last) begin
            addr_nxt     = lsw_r;
            iss_cnt_nxt  = '0;
            proc_cnt_nxt = '0;
            pend_nxt     = 1'b0;
            carry_nxt    = 1'b0;
            used_nxt     = '0;
            state_nxt    = S_ARITH;
          end
        end
      end

      // add or subtract, least significant word first, result written back
      S_ARITH: begin
        pend_nxt = 1'b0;
        if (iss_cnt_r != n_r) begin
          mem_rd_en   = 1'b1;
          wb_addr_nxt = addr_r;
          addr_nxt    = addr_dec(addr_r);
          iss_cnt_nxt = iss_cnt_r + CNTW'(1);
          pend_nxt    = 1'b1;
        end
        if (pend_r) begin
          mem_wr_en    = 1'b1;
          mem_wr_addr  = wb_addr_r;
          mem_wr_data  = {sum[DATA_W-1:0], {DATA_W{1'b0}}};
          carry_nxt    = sum[DATA_W];
          proc_cnt_nxt = proc_cnt_r + CNTW'(1);
          if (sum[DATA_W-1:0] != '0) begin
            used_nxt = proc_cnt_r + CNTW'(1);
          end
          if (proc_cnt_r == n_last) begin
            addr_nxt     = start_r;
            proc_cnt_nxt = '0;
            pend_nxt     = 1'b0;
            state_nxt    = (add_mode && sum[DATA_W]) ? S_OVF : S_EMIT_RD;
          end
        end
      end

      S_OVF: begin
        if (out_chan.ready) begin
          n_nxt     = '0;
          state_nxt = S_LOAD;
        end
      end

      S_EMIT_RD: begin
        mem_rd_en = 1'b1;
        state_nxt = S_EMIT_OUT;
      end

      S_EMIT_OUT: begin
        if (out_chan.ready) begin
          if (proc_cnt_r == n_last) begin
            n_nxt     = '0;
            state_nxt = S_LOAD;
          end else begin
            addr_nxt     = addr_inc(addr_r);
            proc_cnt_nxt = proc_cnt_r + CNTW'(1);
            state_nxt    = S_EMIT_RD;
          end
        end
      end

      default: state_nxt = S_LOAD;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_LOAD;
      ptr_r      <= '0;
      n_r        <= '0;
      sign_r     <= SIGNS_POS_POS;
      iss_cnt_r  <= '0;
      proc_cnt_r <= '0;
      pend_r     <= 1'b0;
      dec_r      <= 1'b0;
      lt_r       <= 1'b0;
      carry_r    <= 1'b0;
      used_r     <= '0;
    end else begin
      state_r    <= state_nxt;
      ptr_r      <= ptr_nxt;
      n_r        <= n_nxt;
      sign_r     <= sign_nxt;
      iss_cnt_r  <= iss_cnt_nxt;
      proc_cnt_r <= proc_cnt_nxt;
      pend_r     <= pend_nxt;
      dec_r      <= dec_nxt;
      lt_r       <= lt_nxt;
      carry_r    <= carry_nxt;
      used_r     <= used_nxt;
    end
  end

  // address registers
  always_ff @(posedge clk) begin
    start_r   <= start_nxt;
    lsw_r     <= lsw_nxt;
    addr_r    <= addr_nxt;
    wb_addr_r <= wb_addr_nxt;
  end

  // operand memory
  always_ff @(posedge clk) begin
    if (mem_wr_en) begin
      mem[mem_wr_addr] <= mem_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_rd_en) begin
      mem_q <= mem[addr_r];
    end
  end

  // loading and result delivery never overlap
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_chan.ready && out_chan.valid))
    else $error("input taken while a result is pending");

  // word count never exceeds the store depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= CNTW'(WORDS))
    else $error("word count beyond store depth");

  // the final result transaction returns the block to loading
  a_last_returns: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && out_chan.ready && out_chan.last_result |=>
      in_chan.ready && (n_r == '0))
    else $error("block not back to loading after last result");

  // an overflow result carries no magnitude
  a_ovf_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && out_chan.overflow |->
      (out_chan.result_word == '0) && (out_chan.used_words == '0) &&
      out_chan.last_result)
    else $error("overflow result carries data");

  // a final word always starts the compare pass
  a_final_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_chan.valid && in_chan.ready && in_chan.final_word |=> (state_r == S_CMP))
    else $error("final word did not start compare");

endmodule

### tb/sbs_checker.sv
`timescale 1ns / 100ps

// watches both channels, predicts every difference and compares field by field
module sbs_checker
  import sbs_pkg::*;
#(
  parameter int unsigned WORDS = WORDS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst_n,
  sbs_in_if           in_mon,
  sbs_out_if          out_mon,
  output int unsigned fail_count,
  output int unsigned pending
);

  typedef struct packed {
    logic [DATA_W-1:0] word;
    logic              negative;
    logic [USED_W-1:0] used;
    logic              overflow;
    logic              last;
  } diff_word_t;

  // operand shift registers, index 0 most significant
  logic [DATA_W-1:0] minuend_sr    [WORDS];
  logic [DATA_W-1:0] subtrahend_sr [WORDS];
  int unsigned       loaded_cnt;
  diff_word_t        expected_diff [$];
  int unsigned       reported;

  initial begin
    fail_count = 0;
    pending    = 0;
    reported   = 0;
  end

  task clear_operands();
    for (int k = 0; k < WORDS; k++) begin
      minuend_sr[k]    = '0;
      subtrahend_sr[k] = '0;
    end
    loaded_cnt = 0;
  endtask

  task shift_in_pair(input logic [DATA_W-1:0] a, input logic [DATA_W-1:0] b);
    for (int k = 0; k < WORDS - 1; k++) begin
      minuend_sr[k]    = minuend_sr[k+1];
      subtrahend_sr[k] = subtrahend_sr[k+1];
    end
    minuend_sr[WORDS-1]    = a;
    subtrahend_sr[WORDS-1] = b;
    if (loaded_cnt < WORDS) loaded_cnt++;
  endtask

  // works out the result words of one operation and queues them
  task predict_difference(input logic [1:0] signs);
    logic [DATA_W-1:0] diff [WORDS];
    logic [DATA_W-1:0] big_w;
    logic [DATA_W-1:0] small_w;
    logic [DATA_W:0]   t;
    logic              carry;
    logic              swapped;
    logic              found;
    logic              add;
    logic              negative;
    int unsigned       lo;
    int unsigned       used;
    diff_word_t        item;
    // magnitude compare, most significant word first
    swapped = 1'b0;
    found   = 1'b0;
    for (int k = 0; k < WORDS; k++) begin
      if (!found && minuend_sr[k] != subtrahend_sr[k]) begin
        swapped = minuend_sr[k] < subtrahend_sr[k];
        found   = 1'b1;
      end
    end
    add   = (signs == SIGNS_POS_NEG) || (signs == SIGNS_NEG_POS);
    lo    = WORDS - loaded_cnt;
    carry = 1'b0;
    // ripple from the least significant loaded word upwards
    for (int p = WORDS - 1; p >= int'(lo); p--) begin
      big_w   = swapped ? subtrahend_sr[p] : minuend_sr[p];
      small_w = swapped ? minuend_sr[p] : subtrahend_sr[p];
      if (add) t = {1'b0, big_w} + {1'b0, small_w} + carry;
      else     t = {1'b0, big_w} - {1'b0, small_w} - carry;
      diff[p] = t[DATA_W-1:0];
      carry   = t[DATA_W];
    end
    if (add && carry) begin
      // carry out of the top word: one flagged transaction only
      item          = '0;
      item.overflow = 1'b1;
      item.last     = 1'b1;
      expected_diff.push_back(item);
    end else begin
      used = 0;
      for (int p = int'(lo); p < WORDS; p++) begin
        if (used == 0 && diff[p] != '0) used = WORDS - p;
      end
      if (used > USED_MAX) used = USED_MAX;
      case (signs)
        SIGNS_POS_POS: negative = swapped;
        SIGNS_POS_NEG: negative = 1'b0;
        SIGNS_NEG_POS: negative = 1'b1;
        default:       negative = !swapped && used != 0;
      endcase
      for (int p = int'(lo); p < WORDS; p++) begin
        item.word     = diff[p];
        item.negative = negative;
        item.used     = used[USED_W-1:0];
        item.overflow = 1'b0;
        item.last     = (p == WORDS - 1);
        expected_diff.push_back(item);
      end
    end
    clear_operands();
  endtask

  task check_result();
    diff_word_t seen;
    diff_word_t want;
    seen = {out_mon.result_word, out_mon.result_negative, out_mon.used_words,
            out_mon.overflow, out_mon.last_result};
    if (expected_diff.size() == 0) begin
      fail_count++;
      if (reported < 10) begin
        reported++;
        $display("%0t checker: result transaction with nothing expected, word %h",
                 $realtime, seen.word);
      end
    end else begin
      want = expected_diff.pop_front();
      if (seen !== want) begin
        fail_count++;
        if (reported < 10) begin
          reported++;
          $display("%0t checker: mismatch word exp %h act %h, neg exp %b act %b",
                   $realtime, want.word, seen.word, want.negative, seen.negative);
          $display("  used exp %0d act %0d, ovf exp %b act %b, last exp %b act %b",
                   want.used, seen.used, want.overflow, seen.overflow,
                   want.last, seen.last);
        end
      end
    end
  endtask

  // sample both channels at the clock edge
  always @(posedge clk) begin
    if (!rst_n) begin
      clear_operands();
      expected_diff.delete();
    end else begin
      if (in_mon.valid && in_mon.ready) begin
        shift_in_pair(in_mon.a_word, in_mon.b_word);
        if (in_mon.final_word) predict_difference({in_mon.a_negative, in_mon.b_negative});
      end
      if (out_mon.valid && out_mon.ready) check_result();
    end
    pending = expected_diff.size();
  end

endmodule

### tb/tb.sv
`timescale 1ns / 100ps

module tb;
  import sbs_pkg::*;

  localparam int unsigned WORDS        = WORDS_DEFAULT;
  localparam int unsigned RANDOM_WORDS = 150;
  localparam int unsigned LONG_HOLD    = 300;
  localparam int unsigned DRAIN_CYCLES = 5 * WORDS + 20;
  localparam int unsigned CYCLE_LIMIT  = 200000;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  sbs_in_if  operand_if ();
  sbs_out_if diff_if ();

  int unsigned       fail_count;
  int unsigned       pending;
  int unsigned       cycle_count;
  int unsigned       burst_left;
  int unsigned       words_sent;
  bit                hold_off_req;
  bit                hold_off_done;
  logic [DATA_W-1:0] op_a [$];
  logic [DATA_W-1:0] op_b [$];

  always #2 clk = ~clk;

  signed_bignum_subtractor_unit #(.WORDS(WORDS)) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (operand_if),
    .out_chan (diff_if)
  );

  sbs_checker #(.WORDS(WORDS)) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (operand_if),
    .out_mon    (diff_if),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // run-away guard
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TB_ERROR");
    $finish;
  end

  // result side: random stall phases, plus one long hold-off on request
  initial begin : result_sink
    int unsigned phase_left;
    int unsigned stall_pct;
    phase_left    = 0;
    stall_pct     = 0;
    diff_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req && !hold_off_done) begin
        diff_if.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_off_done = 1'b1;
      end
      if (phase_left == 0) begin
        case ($urandom_range(3))
          0:       stall_pct = 0;
          1:       stall_pct = 20;
          2:       stall_pct = 50;
          default: stall_pct = 85;
        endcase
        phase_left = $urandom_range(10, 80);
      end
      phase_left--;
      diff_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // mostly random words, with a bias towards the extremes
  function automatic logic [DATA_W-1:0] pick_word();
    case ($urandom_range(4))
      0:       return '0;
      1:       return '1;
      2:       return DATA_W'($urandom_range(3));
      default: return DATA_W'($urandom());
    endcase
  endfunction

  task add_pair(input logic [DATA_W-1:0] a, input logic [DATA_W-1:0] b);
    op_a.push_back(a);
    op_b.push_back(b);
  endtask

  // one operand transaction, with bursts and gaps on the sender side
  task send_word(input logic [DATA_W-1:0] a, input logic [DATA_W-1:0] b,
                 input logic a_neg, input logic b_neg, input logic fin);
    if (burst_left == 0) begin
      if ($urandom_range(3) != 0) begin
        operand_if.valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      burst_left = ($urandom_range(4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
    end
    operand_if.valid      <= 1'b1;
    operand_if.a_word     <= a;
    operand_if.b_word     <= b;
    operand_if.a_negative <= a_neg;
    operand_if.b_negative <= b_neg;
    operand_if.final_word <= fin;
    @(posedge clk);
    while (!operand_if.ready) @(posedge clk);
    burst_left--;
  endtask

  // sends the queued pairs; signs on non-final words are noise
  task send_operation(input logic a_neg, input logic b_neg);
    logic fin;
    for (int i = 0; i < op_a.size(); i++) begin
      fin = (i == op_a.size() - 1);
      send_word(op_a[i], op_b[i], fin ? a_neg : 1'($urandom_range(1)),
                fin ? b_neg : 1'($urandom_range(1)), fin);
    end
    words_sent += op_a.size();
    op_a.delete();
    op_b.delete();
  endtask

  task wait_idle();
    operand_if.valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
  endtask

  initial begin : stimulus
    int unsigned len;
    int unsigned mode;
    int unsigned op_idx;
    int unsigned r;
    bit          paused;
    logic [DATA_W-1:0] a;
    operand_if.valid      = 1'b0;
    operand_if.a_word     = '0;
    operand_if.b_word     = '0;
    operand_if.a_negative = 1'b0;
    operand_if.b_negative = 1'b0;
    operand_if.final_word = 1'b0;
    burst_left    = 0;
    words_sent    = 0;
    hold_off_req  = 1'b0;
    hold_off_done = 1'b0;
    paused        = 1'b0;
    op_idx        = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: plain differences and swaps
    add_pair(32'd5, 32'd3);
    send_operation(1'b0, 1'b0);
    add_pair(32'd3, 32'd5);
    send_operation(1'b0, 1'b0);
    // magnitude addition overflowing a single word
    add_pair(32'hffff_ffff, 32'd1);
    send_operation(1'b0, 1'b1);
    // zero magnitudes with negative minuend keep a negative sign
    add_pair(32'd0, 32'd0);
    send_operation(1'b1, 1'b0);
    // equal negatives give a positive zero
    add_pair(32'd7, 32'd7);
    send_operation(1'b1, 1'b1);
    add_pair(32'd9, 32'd4);
    send_operation(1'b1, 1'b1);
    add_pair(32'd4, 32'd9);
    send_operation(1'b1, 1'b1);
    // borrow across a word boundary
    add_pair(32'd1, 32'd0);
    add_pair(32'd0, 32'd1);
    send_operation(1'b0, 1'b0);
    // carry across a word boundary
    add_pair(32'd0, 32'd0);
    add_pair(32'hffff_ffff, 32'd1);
    send_operation(1'b0, 1'b1);
    // carry out of the top word
    add_pair(32'hffff_ffff, 32'd0);
    add_pair(32'hffff_ffff, 32'd1);
    send_operation(1'b1, 1'b0);
    // all-zero two-word operands
    add_pair(32'd0, 32'd0);
    add_pair(32'd0, 32'd0);
    send_operation(1'b0, 1'b0);
    // swap decided by the upper word
    add_pair(32'd0, 32'hffff_ffff);
    add_pair(32'hffff_ffff, 32'd0);
    send_operation(1'b0, 1'b0);
    wait_idle();

    // random operations, mostly short; the first two are long, WORDS+2 and WORDS pairs
    words_sent = 0;
    while (words_sent < RANDOM_WORDS) begin
      r = $urandom_range(99);
      if (op_idx == 0)      len = WORDS + 2;
      else if (op_idx == 1) len = WORDS;
      else if (r < 75)      len = $urandom_range(1, 4);
      else if (r < 93)      len = $urandom_range(5, 12);
      else                  len = $urandom_range(WORDS - 2, WORDS + 2);
      mode = $urandom_range(2);
      for (int i = 0; i < len; i++) begin
        a = pick_word();
        if (mode == 0 || (mode == 2 && i == len - 1)) add_pair(a, pick_word());
        else add_pair(a, a);
      end
      send_operation(1'($urandom_range(1)), 1'($urandom_range(1)));
      op_idx++;
      if (words_sent >= 60) hold_off_req = 1'b1;
      if (!paused && words_sent >= 120) begin
        paused = 1'b1;
        wait_idle();
      end
    end

    // drain and give the verdict
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### sim.f
rtl/core/sbs_pkg.sv
rtl/core/sbs_ifs.sv
rtl/core/signed_bignum_subtractor_unit.sv
tb/sbs_checker.sv
tb/tb.sv
